FILE: hdl/mlh_pkg.sv
// Shared codes, result type and path reduction table for the left-hand maze solver.
`timescale 1ns / 1ps

package mlh_pkg;

  // Move codes
  localparam logic [2:0] MV_STRAIGHT = 3'd0;
  localparam logic [2:0] MV_LEFT     = 3'd1;
  localparam logic [2:0] MV_RIGHT    = 3'd2;
  localparam logic [2:0] MV_UTURN    = 3'd3;
  localparam logic [2:0] MV_NONE     = 3'd4;

  // Path symbols
  localparam logic [1:0] SYM_S = 2'd0;
  localparam logic [1:0] SYM_L = 2'd1;
  localparam logic [1:0] SYM_R = 2'd2;
  localparam logic [1:0] SYM_O = 2'd3;

  // Reduction result that means "leave the triple alone"
  localparam logic [2:0] RED_NONE = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_GOAL      = 3'd1;
  localparam logic [2:0] ST_DEAD_END  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EXHAUSTED = 3'd4;

  // Sensor codes {left, front, right}
  localparam logic [2:0] SNS_NONE  = 3'b000;
  localparam logic [2:0] SNS_RIGHT = 3'b001;
  localparam logic [2:0] SNS_FRONT = 3'b010;
  localparam logic [2:0] SNS_FR    = 3'b011;
  localparam logic [2:0] SNS_LEFT  = 3'b100;

  // Configuration register word index
  localparam logic REG_RUN_MODE = 1'b0;

  // Run modes
  localparam logic MODE_EXPLORE = 1'b0;
  localparam logic MODE_REPLAY  = 1'b1;

  // One result item
  typedef struct packed {
    logic [2:0] move;
    logic [1:0] heading;
    logic       recorded;
    logic [6:0] path_length;
    logic [2:0] status;
  } result_t;

  // Collapse x O y: SOL,LOS->R; ROL,LOR,SOS->O; LOL,ROR->S; SOR,ROS->L
  function automatic logic [2:0] mlh_reduce(input logic [1:0] x, input logic [1:0] y);
    logic [2:0] r;
    r = RED_NONE;
    case ({x, y})
      {SYM_S, SYM_S}: r = {1'b0, SYM_O};
      {SYM_S, SYM_L}: r = {1'b0, SYM_R};
      {SYM_S, SYM_R}: r = {1'b0, SYM_L};
      {SYM_L, SYM_S}: r = {1'b0, SYM_R};
      {SYM_L, SYM_L}: r = {1'b0, SYM_S};
      {SYM_L, SYM_R}: r = {1'b0, SYM_O};
      {SYM_R, SYM_S}: r = {1'b0, SYM_L};
      {SYM_R, SYM_L}: r = {1'b0, SYM_O};
      {SYM_R, SYM_R}: r = {1'b0, SYM_S};
      default:        r = RED_NONE;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/mlh_ram.sv
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module mlh_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register both reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: hdl/maze_left_hand_path_solver_core.sv
// Top level of the left-hand-rule maze solver with path stack and reduction.
//
//  Channel  Direction  Handshake             Payload
//  in       request in in_valid / in_stall   left_line front_line right_line at_goal new_run
//  out      result out out_valid / out_stall move heading recorded path_length status
//  cfg      APB write  psel penable pwrite   paddr pwdata prdata (run_mode at 0)
//
// Requests are decided, pushed and reduced on acceptance; one per cycle unless in_stall.
// The result register plus a skid register let a request enter while a result waits.
// in_stall rises only when both result registers are full.
// Path stack top sits in a register; the entry below it comes from RAM port A,
// replay symbols from RAM port B. Synchronous reset clears control state; no clear pass.
`timescale 1ns / 1ps

module maze_left_hand_path_solver_core
  import mlh_pkg::*;
#(
  parameter int PATH_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // input requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        left_line,
  input  logic        front_line,
  input  logic        right_line,
  input  logic        at_goal,
  input  logic        new_run,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  move,
  output logic [1:0]  heading,
  output logic        recorded,
  output logic [6:0]  path_length,
  output logic [2:0]  status,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(PATH_DEPTH);
  localparam int CW = $clog2(PATH_DEPTH + 1);

  // Control state
  logic          run_mode;
  logic [CW-1:0] path_count;
  logic [CW-1:0] replay_index;
  logic [1:0]    heading_reg;
  logic          run_finished;
  logic [1:0]    top_sym;

  // Next values
  logic [CW-1:0] path_count_next;
  logic [CW-1:0] replay_index_next;
  logic [1:0]    heading_reg_next;
  logic          run_finished_next;
  logic [1:0]    top_sym_next;

  // Result and skid registers
  result_t res;
  logic    res_valid;
  result_t skid;
  logic    skid_valid;
  result_t res_calc;

  // RAM signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [1:0]    ram_wdata;
  logic [AW-1:0] ram_raddr_a;
  logic [AW-1:0] ram_raddr_b;
  logic [1:0]    second_sym;
  logic [1:0]    replay_sym;

  logic          in_fire;
  logic          out_fire;
  logic [2:0]    code;
  logic [2:0]    mv;
  logic [2:0]    st;
  logic          rec;
  logic          has_sym;
  logic [1:0]    sym;
  logic          push;
  logic [2:0]    red;
  logic          do_reduce;
  logic          cfg_wr;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = skid_valid;
  assign code     = {left_line, front_line, right_line};

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_RUN_MODE);
  assign prdata = (paddr[2] == REG_RUN_MODE) ? {31'b0, run_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode <= MODE_EXPLORE;
    end else if (cfg_wr) begin
      run_mode <= pwdata[0];
    end
  end

  // Decide the move, push and reduce for one request
  always_comb begin
    mv                = MV_NONE;
    st                = ST_OK;
    rec               = 1'b0;
    has_sym           = 1'b0;
    sym               = SYM_S;
    push              = 1'b0;
    red               = RED_NONE;
    do_reduce         = 1'b0;
    path_count_next   = path_count;
    replay_index_next = replay_index;
    run_finished_next = run_finished;
    top_sym_next      = top_sym;
    if (new_run) begin
      if (run_mode == MODE_EXPLORE) begin
        path_count_next = '0;
      end else begin
        replay_index_next = '0;
      end
      run_finished_next = 1'b0;
    end else if (run_finished) begin
      st = ST_GOAL;
    end else if (at_goal) begin
      run_finished_next = 1'b1;
      st                = ST_GOAL;
    end else if (run_mode == MODE_EXPLORE) begin
      unique case (code)
        SNS_NONE:  begin mv = MV_UTURN;    has_sym = 1'b1; sym = SYM_O; end
        SNS_RIGHT: begin mv = MV_RIGHT; end
        SNS_FRONT: begin mv = MV_STRAIGHT; end
        SNS_FR:    begin mv = MV_STRAIGHT; has_sym = 1'b1; sym = SYM_S; end
        SNS_LEFT:  begin mv = MV_LEFT; end
        default:   begin mv = MV_LEFT;     has_sym = 1'b1; sym = SYM_L; end
      endcase
      if (has_sym) begin
        if (path_count >= CW'(PATH_DEPTH)) begin
          mv = MV_NONE;
          st = ST_FULL;
        end else begin
          push      = 1'b1;
          rec       = 1'b1;
          red       = mlh_reduce(second_sym, sym);
          do_reduce = (path_count >= CW'(2)) && (top_sym == SYM_O) && (red != RED_NONE);
          if (do_reduce) begin
            path_count_next = path_count - CW'(1);
            top_sym_next    = red[1:0];
          end else begin
            path_count_next = path_count + CW'(1);
            top_sym_next    = sym;
          end
        end
      end
    end else begin
      unique case (code)
        SNS_NONE:  st = ST_DEAD_END;
        SNS_RIGHT: mv = MV_RIGHT;
        SNS_FRONT: mv = MV_STRAIGHT;
        SNS_LEFT:  mv = MV_LEFT;
        default: begin
          if (replay_index >= path_count || replay_index >= CW'(PATH_DEPTH)) begin
            st = ST_EXHAUSTED;
          end else begin
            replay_index_next = replay_index + CW'(1);
            case (replay_sym)
              SYM_L:   mv = MV_LEFT;
              SYM_S:   mv = MV_STRAIGHT;
              SYM_R:   mv = MV_RIGHT;
              default: mv = MV_NONE;
            endcase
          end
        end
      endcase
    end
  end

  // Turn the heading; a new run starts from north
  always_comb begin
    logic [1:0] base;
    base = new_run ? 2'd0 : heading_reg;
    case (mv)
      MV_LEFT:  heading_reg_next = base + 2'd3;
      MV_RIGHT: heading_reg_next = base + 2'd1;
      MV_UTURN: heading_reg_next = base + 2'd2;
      default:  heading_reg_next = base;
    endcase
  end

  assign res_calc.move        = mv;
  assign res_calc.heading     = heading_reg_next;
  assign res_calc.recorded    = rec;
  assign res_calc.path_length = 7'(path_count_next);
  assign res_calc.status      = st;

  // Advance solver state on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      path_count   <= '0;
      replay_index <= '0;
      heading_reg  <= 2'd0;
      run_finished <= 1'b0;
    end else if (in_fire) begin
      path_count   <= path_count_next;
      replay_index <= replay_index_next;
      heading_reg  <= heading_reg_next;
      run_finished <= run_finished_next;
    end
  end

  // Hold the stack top in a register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      top_sym <= top_sym_next;
    end
  end

  // Write lands at new count - 1, port A reads new count - 2: never the same entry
  assign ram_we      = in_fire && push;
  assign ram_waddr   = AW'(path_count_next - CW'(1));
  assign ram_wdata   = top_sym_next;
  assign ram_raddr_a = in_fire ? AW'(path_count_next - CW'(2)) : AW'(path_count - CW'(2));
  assign ram_raddr_b = in_fire ? AW'(replay_index_next) : AW'(replay_index);

  mlh_ram #(
    .WIDTH (2),
    .DEPTH (PATH_DEPTH)
  ) u_path_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (second_sym),
    .raddr_b (ram_raddr_b),
    .rdata_b (replay_sym)
  );

  // Result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || out_fire) begin
      res_valid  <= skid_valid || in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || out_fire) begin
      res <= skid_valid ? skid : res_calc;
    end else if (in_fire) begin
      skid <= res_calc;
    end
  end

  assign out_valid   = res_valid;
  assign move        = res.move;
  assign heading     = res.heading;
  assign recorded    = res.recorded;
  assign path_length = res.path_length;
  assign status      = res.status;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    path_count <= CW'(PATH_DEPTH))
    else $error("path count beyond depth");

  a_skid_implies_res: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid holds a result while result register is empty");

  a_rec_moves: assert property (@(posedge clk) disable iff (rst)
    in_fire && res_calc.recorded |-> res_calc.move != MV_NONE)
    else $error("recorded symbol without a move");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    in_fire && res_calc.status == ST_FULL |-> path_count == CW'(PATH_DEPTH))
    else $error("path full reported below depth");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    in_fire && push |=>
      (path_count == $past(path_count) + CW'(1)) || (path_count == $past(path_count) - CW'(1)))
    else $error("push changed count by other than one");
`endif

endmodule
